>>> sv/tcw_pkg.sv
package tcw_pkg;

  // default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // cell and character codes
  localparam logic [15:0] ATTR_MASK  = 16'hFF00;
  localparam logic [15:0] BLANK_CELL = 16'h0700;
  localparam logic [7:0]  CHAR_NUL   = 8'h00;
  localparam logic [7:0]  CHAR_NL    = 8'h0A;
  localparam logic [7:0]  CHAR_SPACE = 8'h20;

  // item kind carried on in_tuser
  typedef enum logic {
    ACT_PUT  = 1'b0,
    ACT_READ = 1'b1
  } tcw_action_t;

  // operation of the shared cell unit
  typedef enum logic {
    MRG_CHAR = 1'b0,
    MRG_COPY = 1'b1
  } tcw_mrg_op_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_SCROLL,
    ST_HOLD
  } tcw_state_t;

  // one result item
  typedef struct packed {
    logic [15:0] cell_value;
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic        scrolled;
  } tcw_res_t;

endpackage

>>> sv/tcw_ram.sv
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/tcw_cell_unit.sv
module tcw_cell_unit (
  input  tcw_pkg::tcw_mrg_op_t op,
  input  logic [15:0]          cell_in,
  input  logic [7:0]           char_in,
  output logic [15:0]          cell_out
);

  import tcw_pkg::*;

  // keep attribute and replace character, or pass the cell through unchanged
  always_comb begin
    case (op)
      MRG_CHAR: cell_out = (cell_in & ATTR_MASK) | {8'h00, char_in};
      MRG_COPY: cell_out = cell_in;
      default:  cell_out = cell_in;
    endcase
  end

endmodule

>>> sv/tcw_ctrl.sv
module tcw_ctrl #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input item
  input  logic                             in_valid,
  output logic                             in_ready,
  input  tcw_pkg::tcw_action_t             in_action,
  input  logic [7:0]                       in_char,
  input  logic [10:0]                      in_index,
  // result hand-off to the output register
  input  logic                             out_free,
  output logic                             emit,
  output tcw_pkg::tcw_res_t                res,
  // screen memory
  output logic                             rd_en,
  output logic [$clog2(COLUMNS*ROWS)-1:0]  rd_addr,
  input  logic [15:0]                      rd_data,
  output logic                             wr_en,
  output logic [$clog2(COLUMNS*ROWS)-1:0]  wr_addr,
  output logic [15:0]                      wr_data,
  // shared cell unit
  output tcw_pkg::tcw_mrg_op_t             mrg_op,
  output logic [7:0]                       mrg_char,
  input  logic [15:0]                      mrg_cell
);

  import tcw_pkg::*;

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int LAST_BASE  = CELL_COUNT - COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int CNT_W      = $clog2(CELL_COUNT + 1);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);

  tcw_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [ADDR_W-1:0]  base_r, base_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  tcw_action_t        act_r, act_nxt;
  logic [7:0]         code_r, code_nxt;
  logic [10:0]        idx_r, idx_nxt;
  tcw_res_t           res_r, res_nxt;
  tcw_res_t           res_now;

  logic               is_read, put_live, is_nl, row_adv, scroll_now, in_range;
  logic [31:0]        idx_ext, src_ext, dst_ext, next_base_ext, col_ext, row_ext;
  logic [COL_W-1:0]   col_calc;
  logic [ROW_W-1:0]   row_calc;
  logic               clear_done, scroll_done;

  // decode of the latched item against the cursor
  always_comb begin
    is_read    = (act_r == ACT_READ);
    put_live   = !is_read && (code_r != CHAR_NUL);
    is_nl      = (code_r == CHAR_NL);
    row_adv    = put_live && (is_nl || (32'(col_r) == 32'(COLUMNS - 1)));
    scroll_now = row_adv && (32'(row_r) == 32'(ROWS - 1));
    idx_ext    = 32'(idx_r);
    in_range   = (idx_ext < 32'(CELL_COUNT));
    next_base_ext = 32'(base_r) + 32'(COLUMNS);
    clear_done  = (32'(cnt_r) == 32'(CELL_COUNT - 1));
    scroll_done = (32'(cnt_r) == 32'(CELL_COUNT));
    // scroll copy: read one row down from the count, write the cell at the count minus one
    src_ext = 32'(cnt_r) + ((32'(cnt_r) < 32'(LAST_BASE)) ? 32'(COLUMNS) : 32'd0);
    dst_ext = 32'(cnt_r) - 32'd1;
  end

  // cursor after the item
  always_comb begin
    if (!put_live) begin
      col_calc = col_r;
    end else if (row_adv) begin
      col_calc = '0;
    end else begin
      col_calc = col_r + COL_W'(1);
    end
    if (scroll_now) begin
      row_calc = ROW_W'(ROWS - 1);
    end else if (row_adv) begin
      row_calc = row_r + ROW_W'(1);
    end else begin
      row_calc = row_r;
    end
    col_ext = 32'(col_calc);
    row_ext = 32'(row_calc);
    res_now.cell_value    = (is_read && in_range) ? rd_data : 16'h0000;
    res_now.cursor_column = col_ext[6:0];
    res_now.cursor_row    = row_ext[4:0];
    res_now.scrolled      = scroll_now;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clear_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_ACCESS;
      end
      ST_ACCESS: begin
        if (scroll_now) begin
          state_nxt = ST_SCROLL;
        end else if (!out_free) begin
          state_nxt = ST_HOLD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCROLL: begin
        if (scroll_done) state_nxt = out_free ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // memory, cell unit and hand-off controls
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = addr_r;
    wr_en    = 1'b0;
    wr_addr  = addr_r;
    wr_data  = mrg_cell;
    mrg_op   = MRG_CHAR;
    mrg_char = code_r;
    emit     = 1'b0;
    res      = res_r;
    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt_r[ADDR_W-1:0];
        wr_data = BLANK_CELL;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        rd_en    = in_valid;
        if (in_action == ACT_READ) begin
          rd_addr = ADDR_W'(32'(in_index));
        end
      end
      ST_ACCESS: begin
        wr_en = put_live && !is_nl;
        emit  = !scroll_now && out_free;
        res   = res_now;
      end
      ST_SCROLL: begin
        rd_en    = !scroll_done;
        rd_addr  = src_ext[ADDR_W-1:0];
        wr_en    = (cnt_r != '0);
        wr_addr  = dst_ext[ADDR_W-1:0];
        mrg_op   = (dst_ext < 32'(LAST_BASE)) ? MRG_COPY : MRG_CHAR;
        mrg_char = CHAR_SPACE;
        emit     = scroll_done && out_free;
      end
      ST_HOLD: begin
        emit = out_free;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    cnt_nxt  = cnt_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    base_nxt = base_r;
    addr_nxt = addr_r;
    act_nxt  = act_r;
    code_nxt = code_r;
    idx_nxt  = idx_r;
    res_nxt  = res_r;
    case (state_r)
      ST_CLEAR: begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      ST_IDLE: begin
        if (in_valid) begin
          act_nxt  = in_action;
          code_nxt = in_char;
          idx_nxt  = in_index;
        end
      end
      ST_ACCESS: begin
        cnt_nxt = '0;
        col_nxt = col_calc;
        row_nxt = row_calc;
        res_nxt = res_now;
        if (scroll_now) begin
          base_nxt = ADDR_W'(LAST_BASE);
          addr_nxt = ADDR_W'(LAST_BASE);
        end else if (row_adv) begin
          base_nxt = next_base_ext[ADDR_W-1:0];
          addr_nxt = next_base_ext[ADDR_W-1:0];
        end else if (put_live) begin
          addr_nxt = addr_r + ADDR_W'(1);
        end
      end
      ST_SCROLL: begin
        if (!scroll_done) cnt_nxt = cnt_r + CNT_W'(1);
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
      col_r   <= '0;
      row_r   <= '0;
      base_r  <= '0;
      addr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      base_r  <= base_nxt;
      addr_r  <= addr_nxt;
    end
  end

  // item and pending result
  always_ff @(posedge clk) begin
    act_r  <= act_nxt;
    code_r <= code_nxt;
    idx_r  <= idx_nxt;
    res_r  <= res_nxt;
  end

endmodule

>>> sv/text_console_writer.sv
// channel | dir | tvalid/tready        | tdata / tuser
// in      | in  | in_tvalid/in_tready  | tuser[0] action; tdata char_code, cell_index
// out     | out | out_tvalid/out_tready| tdata cell_value, cursor_column, cursor_row, scrolled
//
// a put or read item: accept, then one screen memory read-modify-write
// a put that moves past the last row adds a scroll pass over all COLUMNS*ROWS cells,
// one cell copied per cycle through the shared cell unit and the single write port
// after reset a clearing pass writes COLUMNS*ROWS cells; in_tready stays low
// the result sits in an output register; a stalled out side holds the next result
// inside and keeps in_tready low until the output register frees
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] char_code, [18:8] cell_index, zero fill
  input  logic [0:0]  in_tuser,   // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [15:0] cell_value, [22:16] cursor_column,
                                  // [27:23] cursor_row, [28] scrolled, zero fill
);

  import tcw_pkg::*;

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  logic              out_valid_r, out_valid_nxt;
  tcw_res_t          out_res_r, out_res_nxt;
  logic              out_free, emit;
  tcw_res_t          res;
  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [15:0]       rd_data, wr_data, mrg_cell;
  tcw_mrg_op_t       mrg_op;
  logic [7:0]        mrg_char;

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (tcw_action_t'(in_tuser[0])),
    .in_char   (in_tdata[7:0]),
    .in_index  (in_tdata[18:8]),
    .out_free  (out_free),
    .emit      (emit),
    .res       (res),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .mrg_op    (mrg_op),
    .mrg_char  (mrg_char),
    .mrg_cell  (mrg_cell)
  );

  tcw_cell_unit u_cell (
    .op       (mrg_op),
    .cell_in  (rd_data),
    .char_in  (mrg_char),
    .cell_out (mrg_cell)
  );

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output register, loaded when a result is handed over
  always_comb begin
    out_free      = !out_valid_r || out_tready;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r.scrolled, out_res_r.cursor_row,
                       out_res_r.cursor_column, out_res_r.cell_value};

endmodule

>>> sv/tcw_checker.sv
module tcw_checker #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  localparam logic [6:0] LAST_COL = 7'(COLUMNS - 1);
  localparam logic [4:0] LAST_ROW = 5'(ROWS - 1);
  localparam bit COL_FITS = (COLUMNS <= 128);
  localparam bit ROW_FITS = (ROWS <= 32);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // no item taken in the first cycle after reset, the clearing pass runs
  a_clear_first: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_tready)
    else $error("item taken during the clearing pass");

  // the block never takes items back to back
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("back to back accept");

  // cursor stays on screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!COL_FITS || out_tdata[22:16] <= LAST_COL) &&
                   (!ROW_FITS || out_tdata[27:23] <= LAST_ROW))
    else $error("cursor off screen");

  // a scroll leaves the cursor at the start of the last row
  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[28] |-> out_tdata[22:16] == 7'd0 &&
                                    out_tdata[27:23] == LAST_ROW)
    else $error("scroll left cursor elsewhere");

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> tb/tb_top.sv
module tb_top;
  import tcw_pkg::*;

  localparam int COLUMNS    = COLUMNS_DEF;
  localparam int ROWS       = ROWS_DEF;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int HOLD_CYCLES = 400;

  // screen tracker: own copy of the cells and cursor, queue of pending replies
  class console_tracker;
    logic [15:0] cells [CELL_COUNT];
    int          col;
    int          row;
    tcw_res_t    replies [$];
    int          errors;

    function new();
      foreach (cells[i]) cells[i] = BLANK_CELL;
      col    = 0;
      row    = 0;
      errors = 0;
    endfunction

    function int pending();
      return replies.size();
    endfunction

    // shift all rows up one and blank the characters of the last row
    function void scroll_screen();
      for (int i = 0; i < CELL_COUNT - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
      for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
        cells[i] = (cells[i] & ATTR_MASK) | {8'h00, CHAR_SPACE};
    endfunction

    // update the screen for one accepted transfer and queue its reply
    function void apply_item(tcw_action_t act, logic [7:0] code, logic [10:0] idx);
      tcw_res_t r;
      int       at;
      r = '0;
      if (act == ACT_READ) begin
        if (idx < CELL_COUNT) r.cell_value = cells[idx];
      end else if (code != CHAR_NUL) begin
        if (code == CHAR_NL) begin
          row++;
          col = 0;
        end else begin
          at = row * COLUMNS + col;
          if (at < CELL_COUNT) cells[at] = (cells[at] & ATTR_MASK) | {8'h00, code};
          col++;
        end
        if (col >= COLUMNS) begin
          row++;
          col = 0;
        end
        if (row >= ROWS) begin
          scroll_screen();
          row        = ROWS - 1;
          col        = 0;
          r.scrolled = 1'b1;
        end
      end
      r.cursor_column = col[6:0];
      r.cursor_row    = row[4:0];
      replies.push_back(r);
    endfunction

    task report(string what, int want, int got);
      $display("mismatch %s: want %0h got %0h (reply %0d pending)", what, want, got,
               replies.size());
      errors++;
    endtask

    // compare one result transfer against the oldest pending reply
    task check_result(logic [31:0] data);
      tcw_res_t want;
      if (replies.size() == 0) begin
        report("reply without request", 0, int'(data));
        return;
      end
      want = replies.pop_front();
      if (data[15:0] != want.cell_value)
        report("cell_value", 32'(want.cell_value), 32'(data[15:0]));
      if (data[22:16] != want.cursor_column)
        report("cursor_column", 32'(want.cursor_column), 32'(data[22:16]));
      if (data[27:23] != want.cursor_row)
        report("cursor_row", 32'(want.cursor_row), 32'(data[27:23]));
      if (data[28] != want.scrolled)
        report("scrolled", 32'(want.scrolled), 32'(data[28]));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // [7:0] char_code, [18:8] cell_index, zero fill
  logic [0:0]  in_tuser = '0;   // [0] action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [15:0] cell_value, [22:16] cursor_column,
                                // [27:23] cursor_row, [28] scrolled

  console_tracker tracker = new();

  int send_idle_pct = 30;
  int recv_idle_pct = 80;
  int items_sent    = 0;
  int cycle_count   = 0;
  bit start_hold    = 1'b0;
  bit rx_hold       = 1'b0;

  text_console_writer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // receiver: random back-pressure, plus the long hold-off
  always @(negedge clk) begin
    out_tready <= !rx_hold && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // result transfers
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_result(out_tdata);
  end

  // long receiver hold-off, counted here while the sender keeps going
  initial begin
    wait (start_hold);
    @(negedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    @(negedge clk);
    rx_hold = 1'b0;
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // offer one input transfer, with random gaps first; returns at the accepting edge
  task send_item(tcw_action_t act, logic [7:0] code, logic [10:0] idx);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {5'b0, idx, code};
    do @(posedge clk); while (!in_tready);
    tracker.apply_item(act, code, idx);
    items_sent++;
  endtask

  task put_char(logic [7:0] code);
    send_item(ACT_PUT, code, 11'($urandom_range(0, 2047)));
  endtask

  task read_cell(logic [10:0] idx);
    send_item(ACT_READ, 8'($urandom_range(0, 255)), idx);
  endtask

  // hold the sender until the block has answered everything
  task drain_replies();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // byte mix: mostly printable, some newlines, NUL, high bytes and anything
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return CHAR_NL;
    if (r < 14) return CHAR_NUL;
    if (r < 26) return 8'($urandom_range(0, 255));
    if (r < 38) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(32, 126));
  endfunction

  // reads mostly land on the cursor row, where the writes are
  function automatic logic [10:0] pick_cell();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 11'($urandom_range(0, 2047));
    if (r < 35) return 11'($urandom_range(0, CELL_COUNT - 1));
    if (r < 45) return 11'($urandom_range(CELL_COUNT - COLUMNS, CELL_COUNT - 1));
    return 11'(tracker.row * COLUMNS + $urandom_range(0, COLUMNS - 1));
  endfunction

  // one random step: a newline burst, a run of text, or a single transfer
  task random_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      repeat ($urandom_range(3, 10)) put_char(CHAR_NL);
    end else if (r < 9) begin
      repeat ($urandom_range(20, 85)) put_char(8'($urandom_range(32, 126)));
    end else if (r < 55) begin
      put_char(pick_char());
    end else begin
      read_cell(pick_cell());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: corner cells, out-of-range reads, NUL, high bytes, newline
    read_cell(11'd0);
    read_cell(11'(CELL_COUNT - 1));
    read_cell(11'(CELL_COUNT));
    read_cell(11'h7FF);
    put_char(CHAR_NUL);
    send_item(ACT_PUT, 8'h41, 11'h7FF);
    put_char(8'hFF);
    put_char(8'h80);
    put_char(8'h7F);
    put_char(8'h01);
    send_item(ACT_READ, 8'hFF, 11'd0);
    read_cell(11'd1);
    read_cell(11'd2);
    read_cell(11'd4);
    put_char(CHAR_NL);
    put_char(CHAR_SPACE);
    read_cell(11'(COLUMNS));
    read_cell(11'h555);
    read_cell(11'h2AA);

    // receiver stalls more than sender idles... reversed after the first third
    while (items_sent < 150) random_step();
    drain_replies();
    send_idle_pct = 80;
    recv_idle_pct = 30;
    while (items_sent < 300) random_step();
    drain_replies();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    start_hold    = 1'b1;
    while (items_sent < 450) random_step();

    // wind down and let the last results drain
    drain_replies();
    repeat (20) @(posedge clk);
    if (tracker.pending() != 0) tracker.report("replies left over", 0, tracker.pending());
    if (tracker.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> text_console_writer.f
sv/tcw_pkg.sv
sv/tcw_ram.sv
sv/tcw_cell_unit.sv
sv/tcw_ctrl.sv
sv/text_console_writer.sv
sv/tcw_checker.sv
tb/tb_top.sv
